// ===== hw/rtl/tcst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcst_pkg;

    // Field and state widths
    localparam int OPCODE_W   = 3;
    localparam int COUNT_W    = 13;
    localparam int HITS_W     = 13;
    localparam int POS_W      = 48;
    localparam int PERIOD_W   = 34;
    localparam int FRAC_W     = 16;
    localparam int SUM_W      = PERIOD_W + 1;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 4;

    // Restoring divider: one quotient bit per cycle over the whole sum
    localparam int DIV_STEPS  = SUM_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(393216000);
    localparam logic [PERIOD_W-1:0] ONE_SAMPLE   = PERIOD_W'(65536);
    localparam logic [HITS_W-1:0]   HITS_MAX     = {HITS_W{1'b1}};

    // Register indexes (byte address / 8)
    localparam logic REG_PERIOD = 1'b0;
    localparam logic REG_SYNC   = 1'b1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADVANCE    = 3'd0,
        OP_MIDI_CLOCK = 3'd1,
        OP_MIDI_START = 3'd2,
        OP_MIDI_STOP  = 3'd3,
        OP_MIDI_CONT  = 3'd4,
        OP_START      = 3'd5,
        OP_STOP       = 3'd6,
        OP_RESET      = 3'd7
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tempo_clock_subdivision_ticker.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Transport clock with sixteenth and quarter tick detection.
// Event channel: event_valid / event_stall carry opcode and sample_count;
// an item is taken when event_valid is high and event_stall is low.
// Tick channel: tick_valid / tick_stall carry one result item per event.
// Config: APB-style port, 64-bit data; sixteenth_period at 0x0, external_sync
// at 0x8. Write config only while the block is idle.
// Sequencing: an advance event while playing in internal mode runs a bit-serial
// restoring divider over the 35-bit phase sum, one quotient bit per cycle,
// in ST_DIV, then passes through ST_DONE to the output register. Every other
// event goes from accept straight to ST_DONE. The block takes one event at a
// time; event_stall is high while an event is in flight.
// The output register holds one finished item; the next event is accepted
// while it waits. If the receiver stalls, the following finished item waits
// in the block and further events are stalled until the output drains.
// Reset: position, phase and pulse counter clear, transport stops,
// sixteenth_period returns to 393216000 and external sync is off.
module tempo_clock_subdivision_ticker #(
    parameter int MAX_BLOCK_SAMPLES  = 4096,
    parameter int PULSES_PER_QUARTER = 24
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    // event channel
    input  wire                                  event_valid,
    output logic                                 event_stall,
    input  wire  [tcst_pkg::OPCODE_W-1:0]        opcode,
    input  wire  [tcst_pkg::COUNT_W-1:0]         sample_count,
    // tick channel
    output logic                                 tick_valid,
    input  wire                                  tick_stall,
    output logic [tcst_pkg::HITS_W-1:0]          sixteenth_hits,
    output logic                                 quarter_hit,
    output logic                                 is_playing,
    output logic [tcst_pkg::POS_W-1:0]           position_samples,
    // configuration port
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [tcst_pkg::CFG_ADDR_W-1:0]      paddr,
    input  wire  [tcst_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [tcst_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    localparam int PULSES_PER_SIXTEENTH = PULSES_PER_QUARTER / 4;
    localparam int PC_W  = $clog2(PULSES_PER_QUARTER + 1);
    localparam int SUB_W = $clog2(PULSES_PER_SIXTEENTH + 1);
    localparam logic [PC_W-1:0]  PPQ_L = PC_W'(PULSES_PER_QUARTER);
    localparam logic [SUB_W-1:0] PPS_L = SUB_W'(PULSES_PER_SIXTEENTH);
    localparam logic [31:0]      MAX_L = 32'(MAX_BLOCK_SAMPLES);

    // Registers
    tcst_pkg::state_t                   state_reg, state_next;
    logic [tcst_pkg::PERIOD_W-1:0]      period_reg, period_next;
    logic                               sync_reg, sync_next;
    logic [tcst_pkg::POS_W-1:0]         pos_reg, pos_next;
    logic [tcst_pkg::PERIOD_W-1:0]      phase_reg, phase_next;
    logic [PC_W-1:0]                    pulse_reg, pulse_next;
    logic [SUB_W-1:0]                   sub_reg, sub_next;
    logic                               running_reg, running_next;
    logic [tcst_pkg::SUM_W-1:0]         div_reg, div_next;
    logic [tcst_pkg::PERIOD_W-1:0]      rem_reg, rem_next;
    logic [tcst_pkg::HITS_W-1:0]        quo_reg, quo_next;
    logic                               ovf_reg, ovf_next;
    logic [tcst_pkg::STEP_W-1:0]        step_reg, step_next;
    logic [tcst_pkg::HITS_W-1:0]        hits_res_reg, hits_res_next;
    logic                               quarter_res_reg, quarter_res_next;
    logic                               out_valid_reg, out_valid_next;
    logic [tcst_pkg::HITS_W-1:0]        out_hits_reg, out_hits_next;
    logic                               out_quarter_reg, out_quarter_next;
    logic                               out_play_reg, out_play_next;
    logic [tcst_pkg::POS_W-1:0]         out_pos_reg, out_pos_next;

    // Combinational helpers
    logic                               accept;
    logic                               cfg_wr;
    logic                               cfg_idx;
    logic                               out_free;
    tcst_pkg::opcode_t                  op;
    logic [tcst_pkg::COUNT_W-1:0]       count_clamped;
    logic [tcst_pkg::PERIOD_W-1:0]      period_eff;
    logic [tcst_pkg::SUM_W-1:0]         sum;
    logic [tcst_pkg::SUM_W-1:0]         trial;
    logic                               trial_ge;
    logic [tcst_pkg::SUM_W-1:0]         trial_diff;
    logic [PC_W-1:0]                    pulse_inc;
    logic [SUB_W-1:0]                   sub_inc;

    assign accept      = event_valid && (state_reg == tcst_pkg::ST_IDLE);
    assign event_stall = (state_reg != tcst_pkg::ST_IDLE);
    assign cfg_wr      = psel && penable && pwrite;
    assign cfg_idx     = paddr[3];
    assign out_free    = !out_valid_reg || !tick_stall;
    assign op          = tcst_pkg::opcode_t'(opcode);
    assign pready      = 1'b1;

    // Read back
    always_comb
    begin
        case (cfg_idx)
            tcst_pkg::REG_PERIOD:
                prdata = {{(tcst_pkg::CFG_DATA_W - tcst_pkg::PERIOD_W){1'b0}}, period_reg};
            tcst_pkg::REG_SYNC:
                prdata = {{(tcst_pkg::CFG_DATA_W - 1){1'b0}}, sync_reg};
            default:
                prdata = '0;
        endcase
    end

    // Advance operands: clamped count, period floored at one sample
    assign count_clamped = (32'(sample_count) > MAX_L) ? MAX_L[tcst_pkg::COUNT_W-1:0]
                                                       : sample_count;
    assign period_eff = (period_reg < tcst_pkg::ONE_SAMPLE) ? tcst_pkg::ONE_SAMPLE
                                                            : period_reg;
    assign sum = {1'b0, phase_reg}
               + {{(tcst_pkg::SUM_W - tcst_pkg::COUNT_W - tcst_pkg::FRAC_W){1'b0}},
                  count_clamped, {tcst_pkg::FRAC_W{1'b0}}};

    // Divider step: shift in next dividend bit, trial subtract
    assign trial      = {rem_reg, div_reg[tcst_pkg::SUM_W-1]};
    assign trial_diff = trial - {1'b0, period_eff};
    assign trial_ge   = (trial >= {1'b0, period_eff});

    // MIDI pulse counters
    assign pulse_inc = pulse_reg + PC_W'(1);
    assign sub_inc   = sub_reg + SUB_W'(1);

    // Sequencer and datapath next state
    always_comb
    begin
        state_next       = state_reg;
        period_next      = period_reg;
        sync_next        = sync_reg;
        pos_next         = pos_reg;
        phase_next       = phase_reg;
        pulse_next       = pulse_reg;
        sub_next         = sub_reg;
        running_next     = running_reg;
        div_next         = div_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        ovf_next         = ovf_reg;
        step_next        = step_reg;
        hits_res_next    = hits_res_reg;
        quarter_res_next = quarter_res_reg;
        out_valid_next   = out_valid_reg && tick_stall;
        out_hits_next    = out_hits_reg;
        out_quarter_next = out_quarter_reg;
        out_play_next    = out_play_reg;
        out_pos_next     = out_pos_reg;

        // config writes (the user writes only while idle; the block does not enforce it)
        if (cfg_wr)
        begin
            case (cfg_idx)
                tcst_pkg::REG_PERIOD:
                    period_next = pwdata[tcst_pkg::PERIOD_W-1:0];
                tcst_pkg::REG_SYNC:
                begin
                    sync_next = pwdata[0];
                    if (pwdata[0])
                    begin
                        pulse_next = '0;
                        sub_next   = '0;
                    end
                end
                default:
                    sync_next = sync_reg;
            endcase
        end

        case (state_reg)
            tcst_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    hits_res_next    = '0;
                    quarter_res_next = 1'b0;
                    state_next       = tcst_pkg::ST_DONE;
                    case (op)
                        tcst_pkg::OP_ADVANCE:
                        begin
                            if (running_reg && !sync_reg)
                            begin
                                pos_next   = pos_reg + tcst_pkg::POS_W'(count_clamped);
                                div_next   = sum;
                                rem_next   = '0;
                                quo_next   = '0;
                                ovf_next   = 1'b0;
                                step_next  = '0;
                                state_next = tcst_pkg::ST_DIV;
                            end
                        end
                        tcst_pkg::OP_MIDI_CLOCK:
                        begin
                            if (sync_reg)
                            begin
                                if (pulse_inc >= PPQ_L)
                                begin
                                    pulse_next       = '0;
                                    sub_next         = '0;
                                    quarter_res_next = 1'b1;
                                end
                                else
                                begin
                                    pulse_next = pulse_inc;
                                    if (sub_inc == PPS_L)
                                    begin
                                        sub_next      = '0;
                                        hits_res_next = tcst_pkg::HITS_W'(1);
                                    end
                                    else
                                    begin
                                        sub_next = sub_inc;
                                    end
                                end
                            end
                        end
                        tcst_pkg::OP_MIDI_START:
                        begin
                            if (sync_reg)
                            begin
                                pos_next     = '0;
                                phase_next   = '0;
                                pulse_next   = '0;
                                sub_next     = '0;
                                running_next = 1'b1;
                            end
                        end
                        tcst_pkg::OP_MIDI_STOP:
                        begin
                            if (sync_reg)
                                running_next = 1'b0;
                        end
                        tcst_pkg::OP_MIDI_CONT:
                        begin
                            if (sync_reg)
                                running_next = 1'b1;
                        end
                        tcst_pkg::OP_START:
                            running_next = 1'b1;
                        tcst_pkg::OP_STOP:
                            running_next = 1'b0;
                        default:
                        begin
                            // local reset command
                            pos_next   = '0;
                            phase_next = '0;
                            pulse_next = '0;
                            sub_next   = '0;
                        end
                    endcase
                end
            end

            tcst_pkg::ST_DIV:
            begin
                // one quotient bit per cycle, quotient saturates with a sticky flag
                div_next  = {div_reg[tcst_pkg::SUM_W-2:0], 1'b0};
                rem_next  = trial_ge ? trial_diff[tcst_pkg::PERIOD_W-1:0]
                                     : trial[tcst_pkg::PERIOD_W-1:0];
                quo_next  = {quo_reg[tcst_pkg::HITS_W-2:0], trial_ge};
                ovf_next  = ovf_reg | quo_reg[tcst_pkg::HITS_W-1];
                step_next = step_reg + tcst_pkg::STEP_W'(1);
                if (step_reg == tcst_pkg::STEP_W'(tcst_pkg::DIV_STEPS - 1))
                begin
                    phase_next    = rem_next;
                    hits_res_next = ovf_next ? tcst_pkg::HITS_MAX : quo_next;
                    state_next    = tcst_pkg::ST_DONE;
                end
            end

            tcst_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_hits_next    = hits_res_reg;
                    out_quarter_next = quarter_res_reg;
                    out_play_next    = running_reg;
                    out_pos_next     = pos_reg;
                    state_next       = tcst_pkg::ST_IDLE;
                end
            end

            default:
                state_next = tcst_pkg::ST_IDLE;
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcst_pkg::ST_IDLE;
            period_reg    <= tcst_pkg::PERIOD_RESET;
            sync_reg      <= 1'b0;
            pos_reg       <= '0;
            phase_reg     <= '0;
            pulse_reg     <= '0;
            sub_reg       <= '0;
            running_reg   <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            period_reg    <= period_next;
            sync_reg      <= sync_next;
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            pulse_reg     <= pulse_next;
            sub_reg       <= sub_next;
            running_reg   <= running_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        div_reg         <= div_next;
        rem_reg         <= rem_next;
        quo_reg         <= quo_next;
        ovf_reg         <= ovf_next;
        hits_res_reg    <= hits_res_next;
        quarter_res_reg <= quarter_res_next;
        out_hits_reg    <= out_hits_next;
        out_quarter_reg <= out_quarter_next;
        out_play_reg    <= out_play_next;
        out_pos_reg     <= out_pos_next;
    end

    assign tick_valid       = out_valid_reg;
    assign sixteenth_hits   = out_hits_reg;
    assign quarter_hit      = out_quarter_reg;
    assign is_playing       = out_play_reg;
    assign position_samples = out_pos_reg;

endmodule

`default_nettype wire
